@@ hw/rtl/crs_pkg.sv @@
`default_nettype none
package crs_pkg;

  // Field widths
  localparam int DIM_W   = 13;
  localparam int ODIM_W  = 9;
  localparam int POS_W   = 8;
  localparam int SLOT_W  = 6;
  localparam int SRC_W   = 12;
  localparam int OFF_W   = 14;
  localparam int DEST_W  = 24;
  localparam int VAL_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int FMT_W   = 2;

  // Derived datapath widths
  localparam int PROD_W     = POS_W + DIM_W;
  localparam int SLOT3_W    = SLOT_W + 2;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;

  // Register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
  localparam logic [ODIM_W-1:0] RST_OUT_WIDTH    = 9'd64;
  localparam logic [ODIM_W-1:0] RST_OUT_HEIGHT   = 9'd64;
  localparam logic [FMT_W-1:0]  RST_PIXEL_FORMAT = 2'd1;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_OUT_WIDTH    = 3'd2,
    REG_OUT_HEIGHT   = 3'd3,
    REG_PIXEL_FORMAT = 3'd4
  } reg_idx_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_GRAY = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_BGR  = 2'd2
  } pix_fmt_t;

  typedef enum logic {
    ACT_COORD = 1'b0,
    ACT_PIXEL = 1'b1
  } action_t;

  // Saturated configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  fw;
    logic [DIM_W-1:0]  fh;
    logic [ODIM_W-1:0] ow;
    logic [ODIM_W-1:0] oh;
    logic [FMT_W-1:0]  fmt;
  } cfg_t;

  // Item fields riding alongside the dividers
  typedef struct packed {
    logic              pixel;
    logic              chan3;
    logic [DIM_W-1:0]  crop_x;
    logic [DIM_W-1:0]  crop_y;
    logic [POS_W-1:0]  ox;
    logic [DEST_W-1:0] dest;
    logic [VAL_W-1:0]  red;
    logic [VAL_W-1:0]  green;
    logic [VAL_W-1:0]  blue;
  } side_t;

  // byte*257 in Q0.16
  function automatic logic [VAL_W-1:0] norm8(input logic [BYTE_W-1:0] b);
    return {b, b};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/crs_req_if.sv @@
`default_nettype none
interface crs_req_if import crs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [SLOT_W-1:0]        slot;
  logic [POS_W-1:0]         out_x;
  logic [POS_W-1:0]         out_y;
  logic signed [DIM_W-1:0]  crop_x;
  logic signed [DIM_W-1:0]  crop_y;
  logic [DIM_W-1:0]         crop_width;
  logic [DIM_W-1:0]         crop_height;
  logic [BYTE_W-1:0]        pixel_byte0;
  logic [BYTE_W-1:0]        pixel_byte1;
  logic [BYTE_W-1:0]        pixel_byte2;

  modport source (
    output valid, action, slot, out_x, out_y, crop_x, crop_y, crop_width, crop_height,
           pixel_byte0, pixel_byte1, pixel_byte2,
    input  ready
  );
  modport sink (
    input  valid, action, slot, out_x, out_y, crop_x, crop_y, crop_width, crop_height,
           pixel_byte0, pixel_byte1, pixel_byte2,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/crs_rsp_if.sv @@
`default_nettype none
interface crs_rsp_if import crs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SRC_W-1:0]  source_x;
  logic [SRC_W-1:0]  source_y;
  logic [OFF_W-1:0]  source_byte_offset;
  logic [DEST_W-1:0] dest_index;
  logic [VAL_W-1:0]  red;
  logic [VAL_W-1:0]  green;
  logic [VAL_W-1:0]  blue;

  modport source (
    output valid, source_x, source_y, source_byte_offset, dest_index, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, source_x, source_y, source_byte_offset, dest_index, red, green, blue,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/crs_config.sv @@
`default_nettype none
module crs_config import crs_pkg::*; #(
  parameter int MAX_FRAME_DIM = 4096,
  parameter int MAX_OUT_DIM   = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [ODIM_W-1:0] out_width;
  logic [ODIM_W-1:0] out_height;
  logic [FMT_W-1:0]  pixel_format;
  logic              wr_en;
  logic [2:0]        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[APB_ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      out_width    <= RST_OUT_WIDTH;
      out_height   <= RST_OUT_HEIGHT;
      pixel_format <= RST_PIXEL_FORMAT;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        REG_OUT_WIDTH:    out_width    <= pwdata[ODIM_W-1:0];
        REG_OUT_HEIGHT:   out_height   <= pwdata[ODIM_W-1:0];
        REG_PIXEL_FORMAT: pixel_format <= pwdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back raw values
  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      REG_OUT_WIDTH:    prdata = APB_DATA_W'(out_width);
      REG_OUT_HEIGHT:   prdata = APB_DATA_W'(out_height);
      REG_PIXEL_FORMAT: prdata = APB_DATA_W'(pixel_format);
      default:          prdata = '0;
    endcase
  end

  // saturate sizes into [1, max]
  always_comb begin
    cfg.fmt = pixel_format;
    if (frame_width == '0)
      cfg.fw = DIM_W'(1);
    else if ({2'b00, frame_width} > 15'(MAX_FRAME_DIM))
      cfg.fw = DIM_W'(MAX_FRAME_DIM);
    else
      cfg.fw = frame_width;
    if (frame_height == '0)
      cfg.fh = DIM_W'(1);
    else if ({2'b00, frame_height} > 15'(MAX_FRAME_DIM))
      cfg.fh = DIM_W'(MAX_FRAME_DIM);
    else
      cfg.fh = frame_height;
    if (out_width == '0)
      cfg.ow = ODIM_W'(1);
    else if ({2'b00, out_width} > 11'(MAX_OUT_DIM))
      cfg.ow = ODIM_W'(MAX_OUT_DIM);
    else
      cfg.ow = out_width;
    if (out_height == '0)
      cfg.oh = ODIM_W'(1);
    else if ({2'b00, out_height} > 11'(MAX_OUT_DIM))
      cfg.oh = ODIM_W'(MAX_OUT_DIM);
    else
      cfg.oh = out_height;
  end

endmodule
`default_nettype wire

@@ hw/rtl/crs_divider.sv @@
`default_nettype none
// Pipelined restoring divider, STEP_BITS quotient bits per stage.
module crs_divider #(
  parameter int NUM_W     = 21,
  parameter int DEN_W     = 9,
  parameter int STEP_BITS = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = STAGES * STEP_BITS;

  logic [DEN_W-1:0] rem_q  [STAGES];
  logic [PAD_W-1:0] num_q  [STAGES];
  logic [PAD_W-1:0] quo_q  [STAGES];
  logic [DEN_W-1:0] rem_in [STAGES];
  logic [PAD_W-1:0] num_in [STAGES];
  logic [PAD_W-1:0] quo_in [STAGES];
  logic [DEN_W-1:0] rem_d  [STAGES];
  logic [PAD_W-1:0] num_d  [STAGES];
  logic [PAD_W-1:0] quo_d  [STAGES];

  assign rem_in[0] = '0;
  assign num_in[0] = PAD_W'(num);
  assign quo_in[0] = '0;

  for (genvar s = 1; s < STAGES; s++) begin : g_link
    assign rem_in[s] = rem_q[s-1];
    assign num_in[s] = num_q[s-1];
    assign quo_in[s] = quo_q[s-1];
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    // shift in the next numerator bit, subtract where it fits
    always_comb begin
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] r;
      logic [PAD_W-1:0] n;
      logic [PAD_W-1:0] q;
      r     = rem_in[s];
      n     = num_in[s];
      q     = quo_in[s];
      trial = '0;
      for (int b = 0; b < STEP_BITS; b++) begin
        trial = {r, n[PAD_W-1]};
        n     = {n[PAD_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          trial = trial - {1'b0, den};
          q     = {q[PAD_W-2:0], 1'b1};
        end else begin
          q     = {q[PAD_W-2:0], 1'b0};
        end
        r = trial[DEN_W-1:0];
      end
      rem_d[s] = r;
      num_d[s] = n;
      quo_d[s] = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo = quo_q[STAGES-1][NUM_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/nearest_neighbour_crop_resampler.sv @@
`default_nettype none
// Nearest-neighbour crop resampler.
// req carries one item per beat. A coordinate request (action 0) returns the
// clamped source pixel, its byte offset in the row and the planar index of its
// red element; a pixel item (action 1) returns the bytes as Q0.16 red, green
// and blue in the configured gray, RGB or BGR order. rsp carries one result
// beat per request beat, in order.
// Registers must be written over the APB port only while no item is in
// flight; the block itself does not enforce this. A result is shown on rsp
// after its request passes one input stage holding the crop products, six
// stages of the two pipelined dividers (four quotient bits each) and the
// clamp feeding the output register. Reset empties the pipeline and loads
// the register defaults. Throughput is one item per cycle unless rsp stalls.
// When rsp is stalled the whole pipeline holds and req.ready drops; nothing
// is lost or repeated, and the pipeline fills again as soon as rsp is taken.
module nearest_neighbour_crop_resampler import crs_pkg::*; #(
  parameter int MAX_FRAME_DIM = 4096,
  parameter int MAX_OUT_DIM   = 256,
  parameter int MAX_BATCH     = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  crs_req_if.sink               req,
  crs_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NSTG = DIV_STAGES + 2;

  cfg_t cfg;

  crs_config #(
    .MAX_FRAME_DIM (MAX_FRAME_DIM),
    .MAX_OUT_DIM   (MAX_OUT_DIM)
  ) u_config (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [NSTG-1:0] vld;
  logic            pipe_en;

  // whole pipeline advances unless the output beat is stuck
  assign pipe_en   = !vld[NSTG-1] || rsp.ready;
  assign req.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pipe_en) begin
      vld <= {vld[NSTG-2:0], req.valid};
    end
  end

  // slot modulo batch size as a constant table
  logic [SLOT_W-1:0] slot_mod_tab [2**SLOT_W];
  for (genvar i = 0; i < 2**SLOT_W; i++) begin : g_slot_tab
    assign slot_mod_tab[i] = SLOT_W'(i % MAX_BATCH);
  end

  logic [SLOT_W-1:0] slot_m;
  assign slot_m = slot_mod_tab[req.slot];

  // input stage
  logic                s1_pixel;
  logic [DIM_W-1:0]    s1_crop_x;
  logic [DIM_W-1:0]    s1_crop_y;
  logic [POS_W-1:0]    s1_ox;
  logic [POS_W-1:0]    s1_oy;
  logic [BYTE_W-1:0]   s1_b0;
  logic [BYTE_W-1:0]   s1_b1;
  logic [BYTE_W-1:0]   s1_b2;
  logic [PROD_W-1:0]   s1_prod_x;
  logic [PROD_W-1:0]   s1_prod_y;
  logic [SLOT3_W-1:0]  s1_slot3;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_pixel  <= req.action;
      s1_crop_x <= req.crop_x;
      s1_crop_y <= req.crop_y;
      s1_ox     <= req.out_x;
      s1_oy     <= req.out_y;
      s1_b0     <= req.pixel_byte0;
      s1_b1     <= req.pixel_byte1;
      s1_b2     <= req.pixel_byte2;
      s1_prod_x <= PROD_W'(req.out_x) * PROD_W'(req.crop_width);
      s1_prod_y <= PROD_W'(req.out_y) * PROD_W'(req.crop_height);
      s1_slot3  <= (SLOT3_W'(slot_m) << 1) + SLOT3_W'(slot_m);
    end
  end

  // floor(out*crop/out_size) for each axis
  logic [PROD_W-1:0] quo_x;
  logic [PROD_W-1:0] quo_y;

  crs_divider #(
    .NUM_W     (PROD_W),
    .DEN_W     (ODIM_W),
    .STEP_BITS (DIV_STEP)
  ) u_div_x (
    .clk (clk),
    .en  (pipe_en),
    .num (s1_prod_x),
    .den (cfg.ow),
    .quo (quo_x)
  );

  crs_divider #(
    .NUM_W     (PROD_W),
    .DEN_W     (ODIM_W),
    .STEP_BITS (DIV_STEP)
  ) u_div_y (
    .clk (clk),
    .en  (pipe_en),
    .num (s1_prod_y),
    .den (cfg.oh),
    .quo (quo_y)
  );

  // side fields: colour and first half of the index (slot3*oh + oy)
  side_t side_d0;
  side_t side_d1;
  side_t side_q [DIV_STAGES];

  always_comb begin
    side_d0        = '0;
    side_d0.pixel  = s1_pixel;
    side_d0.chan3  = (cfg.fmt != FMT_GRAY);
    side_d0.crop_x = s1_crop_x;
    side_d0.crop_y = s1_crop_y;
    side_d0.ox     = s1_ox;
    side_d0.dest   = DEST_W'(s1_slot3) * DEST_W'(cfg.oh) + DEST_W'(s1_oy);
    if (s1_pixel == ACT_PIXEL) begin
      case (cfg.fmt)
        FMT_GRAY: begin
          side_d0.red   = norm8(s1_b0);
          side_d0.green = norm8(s1_b0);
          side_d0.blue  = norm8(s1_b0);
        end
        FMT_BGR: begin
          side_d0.red   = norm8(s1_b2);
          side_d0.green = norm8(s1_b1);
          side_d0.blue  = norm8(s1_b0);
        end
        default: begin
          side_d0.red   = norm8(s1_b0);
          side_d0.green = norm8(s1_b1);
          side_d0.blue  = norm8(s1_b2);
        end
      endcase
    end
  end

  // second half of the index: ow*(slot3*oh + oy) + ox
  always_comb begin
    side_d1      = side_q[0];
    side_d1.dest = DEST_W'(cfg.ow) * side_q[0].dest + DEST_W'(side_q[0].ox);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_q[0] <= side_d0;
      side_q[1] <= side_d1;
      for (int i = 2; i < DIV_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // origin + quotient, clamped to [0, lim-1]
  function automatic logic [DIM_W-1:0] clamp_src(
    input logic [PROD_W-1:0] q,
    input logic [DIM_W-1:0]  org,
    input logic [DIM_W-1:0]  lim
  );
    logic [PROD_W+1:0] s;
    logic [PROD_W+1:0] lim_m1;
    s      = {2'b00, q} + {{(PROD_W+2-DIM_W){org[DIM_W-1]}}, org};
    lim_m1 = (PROD_W+2)'(lim) - (PROD_W+2)'(1);
    if (s[PROD_W+1])
      return '0;
    else if (s > lim_m1)
      return lim_m1[DIM_W-1:0];
    else
      return s[DIM_W-1:0];
  endfunction

  side_t            side_l;
  logic [DIM_W-1:0] sx_d;
  logic [DIM_W-1:0] sy_d;
  logic [OFF_W-1:0] off_d;

  assign side_l = side_q[DIV_STAGES-1];

  always_comb begin
    sx_d  = '0;
    sy_d  = '0;
    off_d = '0;
    if (side_l.pixel == ACT_COORD) begin
      sx_d = clamp_src(quo_x, side_l.crop_x, cfg.fw);
      sy_d = clamp_src(quo_y, side_l.crop_y, cfg.fh);
      if (side_l.chan3)
        off_d = (OFF_W'(sx_d) << 1) + OFF_W'(sx_d);
      else
        off_d = OFF_W'(sx_d);
    end
  end

  // output register
  logic              out_pixel;
  logic [DIM_W-1:0]  out_sx;
  logic [DIM_W-1:0]  out_sy;
  logic [OFF_W-1:0]  out_off;
  logic [DEST_W-1:0] out_dest;
  logic [VAL_W-1:0]  out_red;
  logic [VAL_W-1:0]  out_green;
  logic [VAL_W-1:0]  out_blue;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_pixel <= side_l.pixel;
      out_sx    <= sx_d;
      out_sy    <= sy_d;
      out_off   <= off_d;
      out_dest  <= side_l.dest;
      out_red   <= side_l.red;
      out_green <= side_l.green;
      out_blue  <= side_l.blue;
    end
  end

  assign rsp.valid              = vld[NSTG-1];
  assign rsp.source_x           = out_sx[SRC_W-1:0];
  assign rsp.source_y           = out_sy[SRC_W-1:0];
  assign rsp.source_byte_offset = out_off;
  assign rsp.dest_index         = out_dest;
  assign rsp.red                = out_red;
  assign rsp.green              = out_green;
  assign rsp.blue               = out_blue;

`ifndef SYNTHESIS
  // a stalled pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |=> $stable(vld))
    else $error("pipeline occupancy changed while stalled");

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  // a coordinate result always lies inside the frame
  a_src_in_frame: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (out_pixel == ACT_COORD) |-> (out_sx < cfg.fw) && (out_sy < cfg.fh))
    else $error("source position outside frame");

  // gray pixels give equal channels
  a_gray_equal: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (out_pixel == ACT_PIXEL) && (cfg.fmt == FMT_GRAY)
      |-> (out_red == out_green) && (out_green == out_blue))
    else $error("gray pixel with unequal channels");
`endif

endmodule
`default_nettype wire
